FILE: rtl/modular_exponentiation_defines.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shorthand for the concurrent checks used inside the block.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MODEXP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MODEXP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register indexes, sequencer states and the multiplier interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package modexp_pkg;

   // Operand width used by the arithmetic; port fields stay at DATA_WIDTH.
   localparam int unsigned WIDTH           = 64;
   localparam int unsigned DATA_WIDTH      = 64;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned COUNT_WIDTH     = $clog2(WIDTH);

   typedef logic [WIDTH-1:0]      word_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODULUS  = 1'b0,
      CSR_EXPONENT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_SQUARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     start;
      word_type x;
      word_type y;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

FILE: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular exponentiation shift-add multiplier
// Computes x * y mod m, one multiplier bit per cycle from the top bit down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::word_type    mod_value,
   input  modexp_pkg::mul_cmd_type cmd,
   output modexp_pkg::mul_sts_type sts,
   output modexp_pkg::word_type    product
);
   import modexp_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   word_type               r_ff, r_in;
   word_type               x_ff, x_in;
   word_type               y_ff, y_in;
   word_type               r_dbl;
   word_type               r_step;

   // Sum of two residues, folded back below the modulus.
   function automatic word_type add_mod(word_type a, word_type b, word_type m);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   assign r_dbl  = add_mod(r_ff, r_ff, mod_value);
   assign r_step = y_ff[WIDTH-1] ? add_mod(r_dbl, x_ff, mod_value) : r_dbl;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = COUNT_WIDTH'(WIDTH - 1);
         r_in     = '0;
         x_in     = cmd.x;
         y_in     = cmd.y;
      end else if (busy_ff) begin
         r_in     = r_step;
         y_in     = y_ff << 1;
         count_in = count_ff - COUNT_WIDTH'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      r_ff     <= r_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = r_ff;

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply of one message beat against the key.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Contents
//   req_*       in         message_value, valid/ready
//   rsp_*       out        result_value, valid/ready
//   csr_*       in         modulus (index 0), exponent (index 1), write only
//
// Each modular multiply runs on the shift-add multiplier; a square issued right
// after a multiply starts in the same cycle in which that multiply finishes.
// A beat costs one multiply to reduce the message, then one square per exponent
// bit below the highest set bit plus one multiply for each set bit.
// req_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next beat is taken while it waits.
// Synchronous reset loads modulus 2 and exponent 1 and idles the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  modexp_pkg::data_type                     req_message_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output modexp_pkg::data_type                     rsp_result_value,
   input  logic                                    csr_write_enable,
   input  logic [modexp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  modexp_pkg::data_type                     csr_write_data
);
   import modexp_pkg::*;

   state_type   state_ff, state_in;
   data_type    modulus_ff, exponent_ff;
   word_type    m_ff, m_in;
   word_type    exp_ff, exp_in;
   word_type    acc_ff, acc_in;
   word_type    base_ff, base_in;
   logic        rsp_valid_ff, rsp_valid_in;
   data_type    rsp_value_ff, rsp_value_in;
   logic        rsp_load;
   word_type    m_cfg;
   mul_cmd_type mul_cmd;
   mul_sts_type mul_sts;
   word_type    mul_product;

   assign m_cfg = modulus_ff[WIDTH-1:0];

   modexp_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .mod_value (m_ff),
      .cmd       (mul_cmd),
      .sts       (mul_sts),
      .product   (mul_product)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= DATA_WIDTH'(2);
         exponent_ff <= DATA_WIDTH'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODULUS:  modulus_ff  <= csr_write_data;
            CSR_EXPONENT: exponent_ff <= csr_write_data;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (m_cfg < word_type'(2)) ? ST_CHECK : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_sts.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_MUL_ACC: begin
            if (mul_sts.done) begin
               state_in = (exp_ff[WIDTH-1:1] == '0) ? ST_CHECK : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      m_in          = m_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      mul_cmd.start = 1'b0;
      mul_cmd.x     = base_ff;
      mul_cmd.y     = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               m_in    = m_cfg;
               base_in = '0;
               if (m_cfg < word_type'(2)) begin
                  // No meaningful residue: report zero right away.
                  acc_in = '0;
                  exp_in = '0;
               end else begin
                  // Reduce the message as 1 * message mod m.
                  acc_in        = word_type'(1);
                  exp_in        = exponent_ff[WIDTH-1:0];
                  mul_cmd.start = 1'b1;
                  mul_cmd.x     = word_type'(1);
                  mul_cmd.y     = req_message_value[WIDTH-1:0];
               end
            end
         end
         ST_REDUCE: begin
            if (mul_sts.done) begin
               base_in = mul_product;
            end
         end
         ST_CHECK: begin
            if (exp_ff != '0) begin
               mul_cmd.start = 1'b1;
               if (exp_ff[0]) begin
                  mul_cmd.x = acc_ff;
               end
            end
         end
         ST_MUL_ACC: begin
            if (mul_sts.done) begin
               acc_in = mul_product;
               // The square after the last set bit would never be used.
               if (exp_ff[WIDTH-1:1] == '0) begin
                  exp_in = '0;
               end else begin
                  mul_cmd.start = 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               base_in = mul_product;
               exp_in  = exp_ff >> 1;
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_value_in             = '0;
         rsp_value_in[WIDTH-1:0]  = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   `MODEXP_ASSERT_NOW(a_done_in_mul_state, clock, reset, mul_sts.done,
      state_ff == ST_REDUCE || state_ff == ST_MUL_ACC || state_ff == ST_SQUARE,
      "multiplier finished outside a multiply state")
   `MODEXP_ASSERT_NOW(a_start_when_free, clock, reset, mul_cmd.start, !mul_sts.busy,
      "multiplier started while still busy")
   `MODEXP_ASSERT_NOW(a_residues_reduced, clock, reset,
      state_ff == ST_CHECK && m_ff >= word_type'(2),
      acc_ff < m_ff && base_ff < m_ff,
      "accumulator or base not below the modulus")
   `MODEXP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "block took a beat and stayed ready")

endmodule
